/* design/mp2_pkg.sv */
// Shared types and constants for the 2x2 int8 max-pool stream core.
// No dependencies; every other design file but mp2_ram imports this package.
package mp2_pkg;

    // Default build limits
    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_CHANNELS_DEF = 64;
    localparam int MAX_HEIGHT_DEF   = 4096;

    // Fixed field and register widths
    localparam int SAMPLE_W     = 8;
    localparam int HEIGHT_REG_W = 13;
    localparam int WIDTH_REG_W  = 9;
    localparam int CHAN_REG_W   = 7;
    localparam int BATCH_W      = 16;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 5;
    localparam int IDX_W        = ADDR_W - 2;

    // Register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_POOL_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_CHANNELS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BATCH     = 3'd4;

    typedef enum logic {
        MODE_SAME  = 1'b0,   // stride 1, same-upper padding
        MODE_VALID = 1'b1    // stride 2, valid
    } pool_mode_t;

    // Position flags of the current item, from the position tracker
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic bottom_row;
        logic right_col;
        logic last_chan;
        logic pair_row_end;   // odd row of the last full row pair
        logic pair_col_end;   // odd column of the last full column pair
        logic last_image;     // image counter at the final image of the batch
    } pos_flags_t;

endpackage

/* design/maxpool_2x2_int8_stream_core.sv */
// Output: an accepted item is held in the compare stage; its first result is then
// registered and is on the output from then on; more follow one per cycle while taken.
// Throughput: one item per cycle if each makes at most one result and the output is free;
// an item holds the compare stage until its results (up to 4 at bottom-right) are all out.
// Reset: counters, handshake state and registers (mode 0, sizes 1) clear at once;
// the store RAMs are undefined until written and get no clearing pass.
module maxpool_2x2_int8_stream_core #(
    parameter int MAX_WIDTH    = mp2_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = mp2_pkg::MAX_HEIGHT_DEF,
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mp2_pkg::ADDR_W-1:0]          paddr,
    input  logic [mp2_pkg::DATA_W-1:0]          pwdata,
    output logic [mp2_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    // sample stream in
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [mp2_pkg::SAMPLE_W-1:0] sample_value,
    // pooled results out
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [mp2_pkg::SAMPLE_W-1:0] pooled_value,
    output logic [ROW_W-1:0]                    out_row,
    output logic [COL_W-1:0]                    out_col,
    output logic [CH_W-1:0]                     out_channel,
    output logic                                last_of_run,
    output logic                                last_of_image,
    output logic                                last_of_batch
);
    import mp2_pkg::*;

    localparam int ROW_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int RA_W      = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

    // configuration
    pool_mode_t         mode;
    logic [ROW_W-1:0]   row_last;
    logic [COL_W-1:0]   col_last;
    logic [CH_W-1:0]    chan_last;
    logic [BATCH_W-1:0] batch_last;
    logic               restart;

    // position of the next item
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [CH_W-1:0]    chan;
    logic [RA_W-1:0]    row_addr;
    pos_flags_t         flags;

    // store traffic
    logic                  accept;
    logic                  store_we;
    logic [RA_W-1:0]       row_waddr;
    logic [SAMPLE_W-1:0]   row_wdata, row_rdata;
    logic [CH_W-1:0]       chan_waddr;
    logic [2*SAMPLE_W-1:0] chan_wdata, chan_rdata;

    assign accept = sample_valid && sample_ready;

    mp2_cfg #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mode       (mode),
        .row_last   (row_last),
        .col_last   (col_last),
        .chan_last  (chan_last),
        .batch_last (batch_last),
        .restart    (restart)
    );

    // The tracker steps once per accepted item; a register write restarts the
    // stream at the first sample of the first image.
    mp2_pos #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_pos (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .advance    (accept),
        .row_last   (row_last),
        .col_last   (col_last),
        .chan_last  (chan_last),
        .batch_last (batch_last),
        .row        (row),
        .col        (col),
        .chan       (chan),
        .row_addr   (row_addr),
        .flags      (flags)
    );

    // Previous-row line store, addressed by position within the row
    // (column * channels + channel). Read on accept, written when the item leaves.
    mp2_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ROW_DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .re    (accept),
        .raddr (row_addr),
        .we    (store_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .rdata (row_rdata)
    );

    // Per-channel store: upper byte is the diagonal (previous row, previous
    // column), lower byte the left neighbor in the current row.
    mp2_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (MAX_CHANNELS)
    ) u_chan_ram (
        .clk   (clk),
        .re    (accept),
        .raddr (chan),
        .we    (store_we),
        .waddr (chan_waddr),
        .wdata (chan_wdata),
        .rdata (chan_rdata)
    );

    // Compare stage: holds one item with its read data, pushes its results one
    // per cycle into the output register while it is free, and writes the stores back as the
    // item leaves. A write on the same edge as the next item's read of that entry is bypassed.
    mp2_pool #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT)
    ) u_pool (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample_value  (sample_value),
        .row           (row),
        .col           (col),
        .chan          (chan),
        .row_addr      (row_addr),
        .flags         (flags),
        .row_rdata     (row_rdata),
        .chan_rdata    (chan_rdata),
        .store_we      (store_we),
        .row_waddr     (row_waddr),
        .row_wdata     (row_wdata),
        .chan_waddr    (chan_waddr),
        .chan_wdata    (chan_wdata),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .pooled_value  (pooled_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_channel   (out_channel),
        .last_of_run   (last_of_run),
        .last_of_image (last_of_image),
        .last_of_batch (last_of_batch)
    );

    // image end is always the final result of its item
    a_image_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_image |-> last_of_run)
        else $error("last_of_image without last_of_run");

    // batch end only on an image end
    a_batch_end_on_image_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_batch |-> last_of_image)
        else $error("last_of_batch without last_of_image");

    // result channel stays within the configured channel count
    a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> out_channel <= chan_last)
        else $error("result channel beyond configured count");

    // the input is never stalled while the compare stage has nothing to do
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && $past(!sample_valid) && $past(sample_ready) |-> sample_ready)
        else $error("input stalled with an empty pipeline");

endmodule

/* design/mp2_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Read during write to the same address returns the old contents.
module mp2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/mp2_cfg.sv */
// APB register block: mode, image sizes, batch count; clamped last-index values.
// Depends on mp2_pkg.
module mp2_cfg #(
    parameter int MAX_WIDTH    = mp2_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = mp2_pkg::MAX_HEIGHT_DEF,
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mp2_pkg::ADDR_W-1:0]  paddr,
    input  logic [mp2_pkg::DATA_W-1:0]  pwdata,
    output logic [mp2_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mp2_pkg::pool_mode_t         mode,
    output logic [ROW_W-1:0]            row_last,
    output logic [COL_W-1:0]            col_last,
    output logic [CH_W-1:0]             chan_last,
    output logic [mp2_pkg::BATCH_W-1:0] batch_last,
    output logic                        restart
);
    import mp2_pkg::*;

    pool_mode_t              mode_reg,   mode_next;
    logic [HEIGHT_REG_W-1:0] height_reg, height_next;
    logic [WIDTH_REG_W-1:0]  width_reg,  width_next;
    logic [CHAN_REG_W-1:0]   chan_reg,   chan_next;
    logic [BATCH_W-1:0]      batch_reg,  batch_next;

    logic                    wr;
    logic [IDX_W-1:0]        idx;
    logic [HEIGHT_REG_W-1:0] h_m1;
    logic [WIDTH_REG_W-1:0]  w_m1;
    logic [CHAN_REG_W-1:0]   c_m1;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_comb
    begin
        mode_next   = mode_reg;
        height_next = height_reg;
        width_next  = width_reg;
        chan_next   = chan_reg;
        batch_next  = batch_reg;
        restart     = 1'b0;
        if (wr)
        begin
            unique case (idx)
                REG_POOL_MODE:
                begin
                    mode_next = pool_mode_t'(pwdata[0]);
                    restart   = 1'b1;
                end
                REG_HEIGHT:
                begin
                    height_next = pwdata[HEIGHT_REG_W-1:0];
                    restart     = 1'b1;
                end
                REG_WIDTH:
                begin
                    width_next = pwdata[WIDTH_REG_W-1:0];
                    restart    = 1'b1;
                end
                REG_CHANNELS:
                begin
                    chan_next = pwdata[CHAN_REG_W-1:0];
                    restart   = 1'b1;
                end
                REG_BATCH:
                begin
                    batch_next = pwdata[BATCH_W-1:0];
                    restart    = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SAME;
            height_reg <= HEIGHT_REG_W'(1);
            width_reg  <= WIDTH_REG_W'(1);
            chan_reg   <= CHAN_REG_W'(1);
            batch_reg  <= BATCH_W'(1);
        end
        else
        begin
            mode_reg   <= mode_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            chan_reg   <= chan_next;
            batch_reg  <= batch_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_POOL_MODE: prdata = DATA_W'(mode_reg);
            REG_HEIGHT:    prdata = DATA_W'(height_reg);
            REG_WIDTH:     prdata = DATA_W'(width_reg);
            REG_CHANNELS:  prdata = DATA_W'(chan_reg);
            REG_BATCH:     prdata = DATA_W'(batch_reg);
            default:       prdata = '0;
        endcase
    end

    // Zero acts as one, oversize saturates at the build limit
    assign h_m1 = height_reg - HEIGHT_REG_W'(1);
    assign w_m1 = width_reg - WIDTH_REG_W'(1);
    assign c_m1 = chan_reg - CHAN_REG_W'(1);

    always_comb
    begin
        if (height_reg == '0)
            row_last = '0;
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            row_last = ROW_W'(MAX_HEIGHT - 1);
        else
            row_last = ROW_W'(h_m1);

        if (width_reg == '0)
            col_last = '0;
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(w_m1);

        if (chan_reg == '0)
            chan_last = '0;
        else if (32'(chan_reg) > 32'(MAX_CHANNELS))
            chan_last = CH_W'(MAX_CHANNELS - 1);
        else
            chan_last = CH_W'(c_m1);

        if (batch_reg == '0)
            batch_last = '0;
        else
            batch_last = batch_reg - BATCH_W'(1);
    end

    assign mode = mode_reg;

endmodule

/* design/mp2_pos.sv */
// Stream position tracker: row, column, channel, image counters and row-store address.
// Depends on mp2_pkg.
module mp2_pos #(
    parameter int MAX_WIDTH    = mp2_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = mp2_pkg::MAX_HEIGHT_DEF,
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int RA_W  = (MAX_WIDTH * MAX_CHANNELS > 1) ?
                           $clog2(MAX_WIDTH * MAX_CHANNELS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        restart,
    input  logic                        advance,
    input  logic [ROW_W-1:0]            row_last,
    input  logic [COL_W-1:0]            col_last,
    input  logic [CH_W-1:0]             chan_last,
    input  logic [mp2_pkg::BATCH_W-1:0] batch_last,
    output logic [ROW_W-1:0]            row,
    output logic [COL_W-1:0]            col,
    output logic [CH_W-1:0]             chan,
    output logic [RA_W-1:0]             row_addr,
    output mp2_pkg::pos_flags_t         flags
);
    import mp2_pkg::*;

    logic [ROW_W-1:0]   row_reg,   row_next;
    logic [COL_W-1:0]   col_reg,   col_next;
    logic [CH_W-1:0]    chan_reg,  chan_next;
    logic [RA_W-1:0]    addr_reg,  addr_next;
    logic [BATCH_W-1:0] image_reg, image_next;
    logic [ROW_W-1:0]   rl_m1;
    logic [COL_W-1:0]   cl_m1;

    assign rl_m1 = row_last - ROW_W'(1);
    assign cl_m1 = col_last - COL_W'(1);

    always_comb
    begin
        flags.first_row    = (row_reg == '0);
        flags.first_col    = (col_reg == '0);
        flags.bottom_row   = (row_reg == row_last);
        flags.right_col    = (col_reg == col_last);
        flags.last_chan    = (chan_reg == chan_last);
        flags.pair_row_end = row_reg[0] && ((row_reg >> 1) == (rl_m1 >> 1));
        flags.pair_col_end = col_reg[0] && ((col_reg >> 1) == (cl_m1 >> 1));
        flags.last_image   = (image_reg == batch_last);
    end

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        chan_next  = chan_reg;
        addr_next  = addr_reg;
        image_next = image_reg;
        priority if (restart)
        begin
            row_next   = '0;
            col_next   = '0;
            chan_next  = '0;
            addr_next  = '0;
            image_next = '0;
        end
        else if (advance)
        begin
            addr_next = addr_reg + RA_W'(1);
            if (!flags.last_chan)
            begin
                chan_next = chan_reg + CH_W'(1);
            end
            else
            begin
                chan_next = '0;
                if (!flags.right_col)
                begin
                    col_next = col_reg + COL_W'(1);
                end
                else
                begin
                    col_next  = '0;
                    addr_next = '0;
                    if (!flags.bottom_row)
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        row_next   = '0;
                        image_next = flags.last_image ? '0 : image_reg + BATCH_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            chan_reg  <= '0;
            addr_reg  <= '0;
            image_reg <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            chan_reg  <= chan_next;
            addr_reg  <= addr_next;
            image_reg <= image_next;
        end
    end

    assign row      = row_reg;
    assign col      = col_reg;
    assign chan     = chan_reg;
    assign row_addr = addr_reg;

endmodule

/* design/mp2_pool.sv */
// Compare stage and result sequencer: store read data, forwarding, up to four results.
// Depends on mp2_pkg; drives the write ports of both store RAMs.
module mp2_pool #(
    parameter int MAX_WIDTH    = mp2_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = mp2_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = mp2_pkg::MAX_HEIGHT_DEF,
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int RA_W  = (MAX_WIDTH * MAX_CHANNELS > 1) ?
                           $clog2(MAX_WIDTH * MAX_CHANNELS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mp2_pkg::pool_mode_t                mode,
    // item in
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  logic signed [mp2_pkg::SAMPLE_W-1:0] sample_value,
    input  logic [ROW_W-1:0]                   row,
    input  logic [COL_W-1:0]                   col,
    input  logic [CH_W-1:0]                    chan,
    input  logic [RA_W-1:0]                    row_addr,
    input  mp2_pkg::pos_flags_t                flags,
    // store read data and write ports
    input  logic [mp2_pkg::SAMPLE_W-1:0]       row_rdata,
    input  logic [2*mp2_pkg::SAMPLE_W-1:0]     chan_rdata,
    output logic                               store_we,
    output logic [RA_W-1:0]                    row_waddr,
    output logic [mp2_pkg::SAMPLE_W-1:0]       row_wdata,
    output logic [CH_W-1:0]                    chan_waddr,
    output logic [2*mp2_pkg::SAMPLE_W-1:0]     chan_wdata,
    // results out
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [mp2_pkg::SAMPLE_W-1:0] pooled_value,
    output logic [ROW_W-1:0]                   out_row,
    output logic [COL_W-1:0]                   out_col,
    output logic [CH_W-1:0]                    out_channel,
    output logic                               last_of_run,
    output logic                               last_of_image,
    output logic                               last_of_batch
);
    import mp2_pkg::*;

    localparam logic [1:0] SLOT_FULL   = 2'd0;  // full window, up-left of sample
    localparam logic [1:0] SLOT_RIGHT  = 2'd1;  // vertical pair at right edge
    localparam logic [1:0] SLOT_BOTTOM = 2'd2;  // horizontal pair on bottom row
    localparam logic [1:0] SLOT_CORNER = 2'd3;  // bottom-right copy

    function automatic logic signed [SAMPLE_W-1:0] smax(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // holding stage
    logic                 s1_valid_reg, s1_valid_next;
    logic [3:0]           sent_reg,     sent_next;
    logic                 fwd_row_reg,  fwd_row_next;
    logic                 fwd_chan_reg, fwd_chan_next;
    logic signed [SAMPLE_W-1:0] v_reg;
    logic [ROW_W-1:0]     r_reg;
    logic [COL_W-1:0]     c_reg;
    logic [CH_W-1:0]      ch_reg;
    logic [RA_W-1:0]      addr_reg;
    pos_flags_t           flags_reg;
    logic [SAMPLE_W-1:0]  fwd_row_data_reg;
    logic [2*SAMPLE_W-1:0] fwd_chan_data_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] pooled_reg;
    logic [ROW_W-1:0]     orow_reg;
    logic [COL_W-1:0]     ocol_reg;
    logic [CH_W-1:0]      och_reg;
    logic                 lrun_reg, limg_reg, lbatch_reg;

    logic                 accept, out_free, emit, s1_done, have, is_last, img_end;
    logic [3:0]           mask, pend;
    logic [1:0]           slot;
    logic signed [SAMPLE_W-1:0] up, left, diag, full_max, res_val;
    logic [2*SAMPLE_W-1:0] chan_word;
    logic [ROW_W-1:0]     res_row;
    logic [COL_W-1:0]     res_col;

    // store values, bypassing a write that lands on the edge of the read
    assign up        = fwd_row_reg ? fwd_row_data_reg : row_rdata;
    assign chan_word = fwd_chan_reg ? fwd_chan_data_reg : chan_rdata;
    assign diag      = chan_word[2*SAMPLE_W-1:SAMPLE_W];
    assign left      = chan_word[SAMPLE_W-1:0];
    assign full_max  = smax(smax(diag, up), smax(left, v_reg));

    always_comb
    begin
        unique case (mode)
            MODE_SAME:
            begin
                mask[SLOT_FULL]   = !flags_reg.first_row && !flags_reg.first_col;
                mask[SLOT_RIGHT]  = !flags_reg.first_row && flags_reg.right_col;
                mask[SLOT_BOTTOM] = flags_reg.bottom_row && !flags_reg.first_col;
                mask[SLOT_CORNER] = flags_reg.bottom_row && flags_reg.right_col;
                img_end = flags_reg.bottom_row && flags_reg.right_col && flags_reg.last_chan;
            end
            MODE_VALID:
            begin
                mask    = {3'b000, r_reg[0] && c_reg[0]};
                img_end = r_reg[0] && c_reg[0] && flags_reg.pair_row_end &&
                          flags_reg.pair_col_end && flags_reg.last_chan;
            end
            default:
            begin
                mask    = '0;
                img_end = 1'b0;
            end
        endcase
    end

    assign pend    = mask & ~sent_reg;
    assign have    = |pend;
    assign is_last = ((pend & (pend - 4'd1)) == 4'd0);

    always_comb
    begin
        priority if (pend[SLOT_FULL])
            slot = SLOT_FULL;
        else if (pend[SLOT_RIGHT])
            slot = SLOT_RIGHT;
        else if (pend[SLOT_BOTTOM])
            slot = SLOT_BOTTOM;
        else
            slot = SLOT_CORNER;
    end

    always_comb
    begin
        unique case (slot)
            SLOT_FULL:   res_val = full_max;
            SLOT_RIGHT:  res_val = smax(up, v_reg);
            SLOT_BOTTOM: res_val = smax(left, v_reg);
            default:     res_val = v_reg;
        endcase
        if (mode == MODE_VALID)
        begin
            res_row = r_reg >> 1;
            res_col = c_reg >> 1;
        end
        else
        begin
            res_row = slot[1] ? r_reg : r_reg - ROW_W'(1);
            res_col = slot[0] ? c_reg : c_reg - COL_W'(1);
        end
    end

    // handshakes
    assign out_free     = !out_valid_reg || result_ready;
    assign emit         = s1_valid_reg && have && out_free;
    assign s1_done      = s1_valid_reg && (!have || (emit && is_last));
    assign sample_ready = !s1_valid_reg || s1_done;
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        sent_next      = sent_reg;
        fwd_row_next   = fwd_row_reg;
        fwd_chan_next  = fwd_chan_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            sent_next     = '0;
            fwd_row_next  = s1_done && (row_addr == addr_reg);
            fwd_chan_next = s1_done && (chan == ch_reg);
        end
        else
        begin
            if (s1_done)
                s1_valid_next = 1'b0;
            if (emit)
                sent_next = sent_reg | (4'd1 << slot);
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            sent_reg      <= '0;
            fwd_row_reg   <= 1'b0;
            fwd_chan_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            sent_reg      <= sent_next;
            fwd_row_reg   <= fwd_row_next;
            fwd_chan_reg  <= fwd_chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg             <= sample_value;
            r_reg             <= row;
            c_reg             <= col;
            ch_reg            <= chan;
            addr_reg          <= row_addr;
            flags_reg         <= flags;
            fwd_row_data_reg  <= v_reg;
            fwd_chan_data_reg <= {up, v_reg};
        end
        if (emit)
        begin
            pooled_reg <= res_val;
            orow_reg   <= res_row;
            ocol_reg   <= res_col;
            och_reg    <= ch_reg;
            lrun_reg   <= is_last;
            limg_reg   <= is_last && img_end;
            lbatch_reg <= is_last && img_end && flags_reg.last_image;
        end
    end

    // write back when the item leaves: row <- sample, diag <- up, left <- sample
    assign store_we   = s1_done;
    assign row_waddr  = addr_reg;
    assign row_wdata  = v_reg;
    assign chan_waddr = ch_reg;
    assign chan_wdata = {up, v_reg};

    assign result_valid  = out_valid_reg;
    assign pooled_value  = pooled_reg;
    assign out_row       = orow_reg;
    assign out_col       = ocol_reg;
    assign out_channel   = och_reg;
    assign last_of_run   = lrun_reg;
    assign last_of_image = limg_reg;
    assign last_of_batch = lbatch_reg;

endmodule

/* verif/tb_maxpool_2x2_int8_stream_core.sv */
// Self-checking testbench for maxpool_2x2_int8_stream_core: directed and random sample
// streams in both pooling modes, checked against an in-bench model of the pooling windows.
// Depends on design/mp2_pkg.sv and design/maxpool_2x2_int8_stream_core.sv.
`timescale 1ns / 1ps

module tb_maxpool_2x2_int8_stream_core;
    import mp2_pkg::*;

    localparam int OUT_ROW_W    = $clog2(MAX_HEIGHT_DEF);
    localparam int OUT_COL_W    = $clog2(MAX_WIDTH_DEF);
    localparam int OUT_CH_W     = $clog2(MAX_CHANNELS_DEF);
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;    // results pass the compare stage and output register; leave margin
    localparam int HOLD_CYCLES  = 400;  // long receiver stall for the fill-up test
    localparam int PRINT_CAP    = 50;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // One pooled result as it should appear on the output
    typedef struct {
        sample_t              value;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_CH_W-1:0]  chan;
        logic                 run_end;
        logic                 image_end;
        logic                 batch_end;
    } pool_result_t;

    // DUT connections; every input starts at a known value
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 sample_valid = 1'b0;
    logic                 sample_ready;
    sample_t              sample_value = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    sample_t              pooled_value;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_CH_W-1:0]  out_channel;
    logic                 last_of_run;
    logic                 last_of_image;
    logic                 last_of_batch;

    // Model copy of the configuration registers (raw values, as written)
    pool_mode_t               pool_sel = MODE_SAME;
    logic [HEIGHT_REG_W-1:0]  height_reg = 1;
    logic [WIDTH_REG_W-1:0]   width_reg = 1;
    logic [CHAN_REG_W-1:0]    chan_reg = 1;
    logic [BATCH_W-1:0]       batch_reg = 1;

    // Model copy of the line stores and stream position
    sample_t     above_mem [MAX_WIDTH_DEF*MAX_CHANNELS_DEF];  // previous row, per col/chan
    sample_t     left_mem [MAX_CHANNELS_DEF];                  // current row, previous col
    sample_t     diag_mem [MAX_CHANNELS_DEF];                  // previous row, previous col
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;
    int unsigned chan_pos = 0;
    int unsigned image_pos = 0;

    pool_result_t expected_q [$];   // pooled results still owed by the DUT
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_req = 0;     // bumped by a test to ask for a long receiver stall
    int           hold_ack = 0;
    int           hold_left = 0;

    maxpool_2x2_int8_stream_core dut (.*);

    always #5 clk = ~clk;

    // Hard stop in case the DUT hangs or drops results
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("maxpool_2x2_int8_stream_core: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long stretch on request so the core backs up
    always @(posedge clk) begin
        if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else begin
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Every accepted result is matched against the oldest expectation
    always @(posedge clk) begin : result_check
        pool_result_t want;
        if (rst_n && result_valid && result_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with none expected", pooled_value, 0);
            end
            else begin
                want = expected_q.pop_front();
                check_field("pooled_value", pooled_value, want.value);
                check_field("out_row", out_row, want.row);
                check_field("out_col", out_col, want.col);
                check_field("out_channel", out_channel, want.chan);
                check_field("last_of_run", last_of_run, want.run_end);
                check_field("last_of_image", last_of_image, want.image_end);
                check_field("last_of_batch", last_of_batch, want.batch_end);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Pooling model
    // ---------------------------------------------------------------------

    // Zero acts as one; oversize saturates at the build limit
    function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic sample_t smax(input sample_t a, input sample_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pool_result_t make_result(input sample_t v, input int unsigned r,
                                                 input int unsigned c, input int unsigned ch);
        pool_result_t res;
        res.value = v;
        res.row = OUT_ROW_W'(r);
        res.col = OUT_COL_W'(c);
        res.chan = OUT_CH_W'(ch);
        res.run_end = 1'b0;
        res.image_end = 1'b0;
        res.batch_end = 1'b0;
        return res;
    endfunction

    // Works out the results one accepted sample releases, then advances the position
    task automatic predict_pool(input sample_t v);
        int unsigned  h, w, nch, nb, idx;
        sample_t      up, lf, dg;
        logic         img_done;
        pool_result_t step_q [$];
        h = eff_size(height_reg, MAX_HEIGHT_DEF);
        w = eff_size(width_reg, MAX_WIDTH_DEF);
        nch = eff_size(chan_reg, MAX_CHANNELS_DEF);
        nb = (batch_reg == 0) ? 1 : batch_reg;
        img_done = 1'b0;
        idx = col_pos * MAX_CHANNELS_DEF + chan_pos;
        up = above_mem[idx];
        lf = left_mem[chan_pos];
        dg = diag_mem[chan_pos];

        if (pool_sel == MODE_SAME) begin
            // window anchored one row up; clipped to a vertical pair at the right edge
            if (row_pos >= 1) begin
                if (col_pos >= 1)
                    step_q.push_back(make_result(smax(smax(dg, up), smax(lf, v)),
                                                 row_pos - 1, col_pos - 1, chan_pos));
                if (col_pos == w - 1)
                    step_q.push_back(make_result(smax(up, v), row_pos - 1, col_pos, chan_pos));
            end
            // bottom row: horizontal pair, and a plain copy at the corner
            if (row_pos == h - 1) begin
                if (col_pos >= 1)
                    step_q.push_back(make_result(smax(lf, v), row_pos, col_pos - 1, chan_pos));
                if (col_pos == w - 1)
                    step_q.push_back(make_result(v, row_pos, col_pos, chan_pos));
            end
            img_done = (row_pos == h - 1) && (col_pos == w - 1) && (chan_pos == nch - 1);
        end
        else if ((row_pos % 2 == 1) && (col_pos % 2 == 1)) begin
            // stride 2: the odd/odd sample closes a full block; odd edges never get here
            step_q.push_back(make_result(smax(smax(dg, up), smax(lf, v)),
                                         row_pos / 2, col_pos / 2, chan_pos));
            img_done = (row_pos == (h / 2) * 2 - 1) && (col_pos == (w / 2) * 2 - 1) &&
                       (chan_pos == nch - 1);
        end

        diag_mem[chan_pos] = up;
        left_mem[chan_pos] = v;
        above_mem[idx] = v;

        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].run_end = 1'b1;
            if (img_done) begin
                step_q[step_q.size() - 1].image_end = 1'b1;
                step_q[step_q.size() - 1].batch_end = (image_pos >= nb - 1);
            end
        end
        foreach (step_q[i])
            expected_q.push_back(step_q[i]);

        // raster advance: channel, column, row, image
        chan_pos++;
        if (chan_pos >= nch) begin
            chan_pos = 0;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos = 0;
                    image_pos++;
                    if (image_pos >= nb)
                        image_pos = 0;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Bus and stream drivers
    // ---------------------------------------------------------------------

    // APB write, then read back the same register. Any write restarts the stream.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        // register takes the value at this edge
        want = '0;
        case (idx)
            REG_POOL_MODE: begin
                pool_sel = pool_mode_t'(val[0]);
                want = DATA_W'(pool_sel);
            end
            REG_HEIGHT: begin
                height_reg = val[HEIGHT_REG_W-1:0];
                want = DATA_W'(height_reg);
            end
            REG_WIDTH: begin
                width_reg = val[WIDTH_REG_W-1:0];
                want = DATA_W'(width_reg);
            end
            REG_CHANNELS: begin
                chan_reg = val[CHAN_REG_W-1:0];
                want = DATA_W'(chan_reg);
            end
            REG_BATCH: begin
                batch_reg = val[BATCH_W-1:0];
                want = DATA_W'(batch_reg);
            end
            default: want = '0;
        endcase
        row_pos = 0;
        col_pos = 0;
        chan_pos = 0;
        image_pos = 0;
        // psel stays up straight into the read setup
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        check_field($sformatf("readback of register %0d", idx), prdata, want);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one item, with a random gap first; returns at the edge it is taken
    task automatic send_sample(input sample_t v);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_value <= v;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        predict_pool(v);
    endtask

    // Stream idle: all owed results back, then time for items with no result to clear
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Leans on the extremes so ties and limits turn up often
    function automatic sample_t random_sample();
        case ($urandom_range(7))
            0: return -8'sd128;
            1: return 8'sd127;
            default: return sample_t'($urandom_range(255));
        endcase
    endfunction

    task automatic config_image(input pool_mode_t m, input logic [DATA_W-1:0] h,
                                input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] c,
                                input logic [DATA_W-1:0] b);
        wait_idle();
        write_reg(REG_POOL_MODE, DATA_W'(m));
        write_reg(REG_HEIGHT, h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_CHANNELS, c);
        write_reg(REG_BATCH, b);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Out of reset every size is one, so each sample comes straight back as a copy
    task automatic test_reset_defaults();
        send_sample(8'sd127);
        send_sample(-8'sd128);
    endtask

    // 2x2x2 image in stride 1: full window, right-edge pair, bottom pair, corner copy;
    // the last sample releases four results
    task automatic test_same_mode_edges();
        config_image(MODE_SAME, 2, 2, 2, 1);
        send_sample(-8'sd128);
        send_sample(8'sd127);
        send_sample(8'sd127);
        send_sample(-8'sd128);
        send_sample(8'sd0);
        send_sample(-8'sd1);
        send_sample(-8'sd1);
        send_sample(8'sd0);
    endtask

    // 3x3 in stride 2: one block, odd last row and column dropped
    task automatic test_valid_mode_blocks();
        config_image(MODE_VALID, 3, 3, 1, 1);
        send_sample(-8'sd128);
        send_sample(-8'sd100);
        send_sample(8'sd5);
        send_sample(8'sd127);
        send_sample(-8'sd1);
        send_sample(8'sd0);
        send_sample(8'sd100);
        send_sample(-8'sd128);
        send_sample(8'sd50);
    endtask

    // Stop mid-image, rewrite height to one: stream restarts and the stride-2 image
    // with a single row yields nothing at all
    task automatic test_restart_empty_image();
        send_sample(8'sd9);
        send_sample(-8'sd9);
        wait_idle();
        write_reg(REG_HEIGHT, 1);
        send_sample(8'sd127);
        send_sample(-8'sd128);
        send_sample(8'sd3);
    endtask

    // Sizes written as zero behave as one
    task automatic test_zero_sizes();
        config_image(MODE_SAME, 0, 0, 0, 0);
        send_sample(8'sd42);
        send_sample(-8'sd42);
    endtask

    // Two one-row images: batch end only on the second image
    task automatic test_batch_end();
        config_image(MODE_SAME, 1, 2, 1, 2);
        send_sample(8'sd1);
        send_sample(-8'sd128);
        send_sample(8'sd127);
        send_sample(-8'sd2);
    endtask

    // Receiver holds off for a long stretch while samples keep coming, so the core
    // fills and must drop sample_ready
    task automatic test_output_backpressure();
        config_image(MODE_SAME, 4, 4, 2, 1);
        hold_req++;
        repeat (32) send_sample(random_sample());
    endtask

    // Oversize channel count saturates at 64: one pixel, image end on channel 63
    task automatic test_size_limits();
        config_image(MODE_SAME, 1, 1, '1, 1);
        repeat (64) send_sample(random_sample());
    endtask

    // Random small shapes and modes, whole batches and cut-off streams alike
    task automatic test_random_streams(input int unsigned n_items);
        int unsigned sent, total, burst;
        sent = 0;
        while (sent < n_items) begin
            config_image(pool_mode_t'($urandom_range(1)), $urandom_range(0, 5),
                         $urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 3));
            total = eff_size(height_reg, MAX_HEIGHT_DEF) * eff_size(width_reg, MAX_WIDTH_DEF) *
                    eff_size(chan_reg, MAX_CHANNELS_DEF) * ((batch_reg == 0) ? 1 : batch_reg);
            burst = $urandom_range(1, 2 * total);
            if (burst > n_items - sent)
                burst = n_items - sent;
            repeat (burst) send_sample(random_sample());
            sent += burst;
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender sparse-ish, receiver mostly stalled
        send_idle_pct = 36;
        recv_idle_pct = 80;
        test_reset_defaults();
        test_same_mode_edges();
        test_valid_mode_blocks();
        test_restart_empty_image();
        test_zero_sizes();
        test_batch_end();

        // sender mostly idle, receiver mostly ready
        send_idle_pct = 80;
        recv_idle_pct = 36;
        test_output_backpressure();
        test_random_streams(40);

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_size_limits();
        test_random_streams(40);

        wait_idle();
        if (mismatch_count == 0)
            $display("maxpool_2x2_int8_stream_core: match");
        else
            $display("maxpool_2x2_int8_stream_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/mp2_pkg.sv
design/mp2_ram.sv
design/mp2_cfg.sv
design/mp2_pos.sv
design/mp2_pool.sv
design/maxpool_2x2_int8_stream_core.sv
verif/tb_maxpool_2x2_int8_stream_core.sv
